// File: rtl/rti_pkg.sv
`timescale 1ns / 1ps

package rti_pkg;

    localparam int SLOT_BITS   = 10;
    localparam int FIELD_BITS  = 32;
    localparam int IN_DATA_W   = 224;
    localparam int OUT_DATA_W  = 32;
    localparam int DIST_BITS   = 31;
    localparam int MD_BITS     = 16;
    localparam int FRAC_BITS   = 16;
    localparam int APB_AW      = 3;

    localparam logic [MD_BITS-1:0] MIN_DISTANCE_RESET = 16'd7;
    localparam logic               REG_MIN_DISTANCE   = 1'b0;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_TEST  = 1'b1
    } action_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } ctrl_t;

endpackage

// File: rtl/rti_ram.sv
`timescale 1ns / 1ps

module rti_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/rti_delay.sv
`timescale 1ns / 1ps

module rti_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sh_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                sh_reg[i] <= '0;
            end
        end else if (en) begin
            sh_reg[0] <= din;
            for (int i = 1; i < N; i++) begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    assign dout = sh_reg[N-1];

endmodule

// File: rtl/rti_mul.sv
`timescale 1ns / 1ps

module rti_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA  = (AW + 31) / 32;
    localparam int NB  = (BW + 31) / 32;
    localparam int PW  = AW + BW;
    localparam int ACW = (NA + NB) * 32;

    logic [AW-1:0]        abs_a;
    logic [BW-1:0]        abs_b;
    logic [NA*32-1:0]     ma_reg;
    logic [NB*32-1:0]     mb_reg;
    logic                 neg1_reg;
    logic [63:0]          pp_reg [NA][NB];
    logic                 neg2_reg;
    logic [ACW-1:0]       acc;
    logic [PW-1:0]        sum_reg;
    logic                 neg3_reg;
    logic signed [PW-1:0] p_reg;

    always_comb begin
        abs_a = a[AW-1] ? AW'(-a) : AW'(a);
        abs_b = b[BW-1] ? BW'(-b) : BW'(b);
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (ACW'(pp_reg[i][j]) << (32 * (i + j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg   <= (NA*32)'(abs_a);
            mb_reg   <= (NB*32)'(abs_b);
            neg1_reg <= a[AW-1] ^ b[BW-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= ma_reg[i*32 +: 32] * mb_reg[j*32 +: 32];
                end
            end
            neg2_reg <= neg1_reg;
            sum_reg  <= acc[PW-1:0];
            neg3_reg <= neg2_reg;
            p_reg    <= neg3_reg ? PW'(-sum_reg) : PW'(sum_reg);
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/rti_div.sv
`timescale 1ns / 1ps

module rti_div #(
    parameter int NUMW = 118,
    parameter int DENW = 102,
    parameter int QW   = 31
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  rti_pkg::ctrl_t     in_tag,
    input  logic [NUMW-1:0]    num,
    input  logic [DENW-1:0]    den,
    output rti_pkg::ctrl_t     out_tag,
    output logic [QW-1:0]      quo
);

    import rti_pkg::*;

    localparam int RW = ((NUMW > DENW + QW) ? NUMW : DENW + QW) + 1;

    logic [RW-1:0] rem_reg [QW+1];
    logic [RW-1:0] den_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          sat_reg [QW+1];
    ctrl_t         tag_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= in_tag;
        end
        if (en) begin
            rem_reg[0] <= RW'(num);
            den_reg[0] <= RW'(den);
            q_reg[0]   <= '0;
            sat_reg[0] <= RW'(num) >= (RW'(den) << QW);
        end
    end

    for (genvar i = 1; i <= QW; i++) begin : g_step
        localparam int B = QW - i;
        logic [RW-1:0] cand;
        logic          take;

        always_comb begin
            cand = den_reg[i-1] << B;
            take = rem_reg[i-1] >= cand;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i] <= '0;
            end else if (en) begin
                tag_reg[i] <= tag_reg[i-1];
            end
            if (en) begin
                rem_reg[i] <= take ? rem_reg[i-1] - cand : rem_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (QW'(take) << B);
                sat_reg[i] <= sat_reg[i-1];
            end
        end
    end

    assign out_tag = tag_reg[QW];
    assign quo     = sat_reg[QW] ? {QW{1'b1}} : q_reg[QW];

endmodule

// File: rtl/ray_triangle_intersect_unit.sv
`timescale 1ns / 1ps

// Ray/triangle test by Cramer's rule over a table of VERTEX_SLOTS vertices. A write item
// (tuser 0) stores one vertex; a test item (tuser 1) names three slots and a ray and returns
// hit and the Q16.16 distance, rounded down, saturated at 0x7FFFFFFF. Every item, write or test,
// gives exactly one result. The pipeline takes one item per clock; its depth is set by
// the two four-stage multiplier banks, the distance compare multiplier and the 32-stage
// divider (a saturation check, then one quotient bit per stage). When the result side
// stalls the whole pipeline holds. Slots beyond the table wrap modulo VERTEX_SLOTS, and a
// test may only name slots written since reset.

module ray_triangle_intersect_unit #(
    parameter int VERTEX_SLOTS = 1024,
    parameter int COORD_BITS   = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vertex_a, vertex_b, vertex_c, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, zero pad
    input  logic [rti_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance, zero pad
    output logic [rti_pkg::OUT_DATA_W-1:0]    m_tdata,
    // hit
    output logic                              m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rti_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    import rti_pkg::*;

    localparam int SAW  = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int CW   = COORD_BITS;
    localparam int EW   = CW + 1;
    localparam int KW   = 2 * EW + 1;
    localparam int PW   = EW + KW;
    localparam int SW   = PW + 2;
    localparam int NUMW = SW + FRAC_BITS;
    localparam int MDW  = MD_BITS + 1;
    localparam int MPW  = MDW + SW;

    function automatic logic signed [CW-1:0] coord(input logic [FIELD_BITS-1:0] f);
        logic signed [63:0] w;
        w = 64'(signed'(f));
        return w[CW-1:0];
    endfunction

    function automatic logic [SAW-1:0] wrap(input logic [SLOT_BITS-1:0] s);
        logic [31:0] v;
        v = 32'(s);
        for (int k = SLOT_BITS - 1; k >= 0; k--) begin
            if (v >= (32'(VERTEX_SLOTS) << k)) begin
                v = v - (32'(VERTEX_SLOTS) << k);
            end
        end
        return v[SAW-1:0];
    endfunction

    logic                en;
    logic                in_acc;
    logic [MD_BITS-1:0]  md_reg;
    logic [SLOT_BITS-1:0] slot [3];
    logic signed [CW-1:0] in_pos [3];
    logic signed [CW-1:0] in_dir [3];
    logic [3*CW-1:0]     rd [3];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign in_acc   = s_tvalid && s_tready;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_DISTANCE) ? 32'(md_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            md_reg <= MIN_DISTANCE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_DISTANCE) begin
            md_reg <= pwdata[MD_BITS-1:0];
        end
    end

    // field unpack
    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign slot[i]   = s_tdata[i*SLOT_BITS +: SLOT_BITS];
        assign in_pos[i] = coord(s_tdata[3*SLOT_BITS + i*FIELD_BITS +: FIELD_BITS]);
        assign in_dir[i] = coord(s_tdata[3*SLOT_BITS + (3+i)*FIELD_BITS +: FIELD_BITS]);
    end

    // vertex table, one copy per corner
    for (genvar i = 0; i < 3; i++) begin : g_ram
        rti_ram #(
            .WIDTH(3*CW),
            .DEPTH(VERTEX_SLOTS)
        ) u_ram (
            .aclk (aclk),
            .we   (in_acc && action_t'(s_tuser) == ACT_WRITE),
            .waddr(wrap(slot[0])),
            .wdata({in_pos[2], in_pos[1], in_pos[0]}),
            .re   (en),
            .raddr(wrap(slot[i])),
            .rdata(rd[i])
        );
    end

    // stage 1: input registers beside table read
    logic                 p1_valid_reg;
    logic                 p1_test_reg;
    logic signed [CW-1:0] p1_pos_reg [3];
    logic signed [CW-1:0] p1_dir_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_tvalid;
        end
        if (en) begin
            p1_test_reg <= action_t'(s_tuser) == ACT_TEST;
            for (int i = 0; i < 3; i++) begin
                p1_pos_reg[i] <= in_pos[i];
                p1_dir_reg[i] <= in_dir[i];
            end
        end
    end

    // stage 2: edges and origin offset
    logic                 p2_valid_reg;
    logic                 p2_test_reg;
    logic signed [EW-1:0] e01_reg [3];
    logic signed [EW-1:0] e02_reg [3];
    logic signed [EW-1:0] wo_reg  [3];
    logic signed [EW-1:0] rd_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
        if (en) begin
            p2_test_reg <= p1_test_reg;
            for (int i = 0; i < 3; i++) begin
                e01_reg[i] <= EW'(signed'(rd[0][i*CW +: CW])) - EW'(signed'(rd[1][i*CW +: CW]));
                e02_reg[i] <= EW'(signed'(rd[0][i*CW +: CW])) - EW'(signed'(rd[2][i*CW +: CW]));
                wo_reg[i]  <= EW'(signed'(rd[0][i*CW +: CW])) - EW'(p1_pos_reg[i]);
                rd_reg[i]  <= EW'(p1_dir_reg[i]);
            end
        end
    end

    // minors
    logic signed [EW-1:0]   ma [12];
    logic signed [EW-1:0]   mb [12];
    logic signed [2*EW-1:0] mp [12];
    logic signed [KW-1:0]   k_reg [6];

    assign ma[0]  = e02_reg[1]; assign mb[0]  = rd_reg[2];
    assign ma[1]  = rd_reg[1];  assign mb[1]  = e02_reg[2];
    assign ma[2]  = wo_reg[1];  assign mb[2]  = rd_reg[2];
    assign ma[3]  = rd_reg[1];  assign mb[3]  = wo_reg[2];
    assign ma[4]  = e02_reg[1]; assign mb[4]  = wo_reg[2];
    assign ma[5]  = wo_reg[1];  assign mb[5]  = e02_reg[2];
    assign ma[6]  = rd_reg[1];  assign mb[6]  = e01_reg[2];
    assign ma[7]  = e01_reg[1]; assign mb[7]  = rd_reg[2];
    assign ma[8]  = e01_reg[1]; assign mb[8]  = e02_reg[2];
    assign ma[9]  = e02_reg[1]; assign mb[9]  = e01_reg[2];
    assign ma[10] = e01_reg[1]; assign mb[10] = wo_reg[2];
    assign ma[11] = wo_reg[1];  assign mb[11] = e01_reg[2];

    for (genvar i = 0; i < 12; i++) begin : g_mul1
        rti_mul #(.AW(EW), .BW(EW)) u_mul (
            .aclk(aclk), .en(en), .a(ma[i]), .b(mb[i]), .p(mp[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                k_reg[i] <= KW'(mp[2*i]) - KW'(mp[2*i+1]);
            end
        end
    end

    // x terms held until minors are ready
    logic [4*EW-1:0]      xd;
    logic signed [EW-1:0] e01x_d, e02x_d, wox_d, rdx_d;

    rti_delay #(.W(4*EW), .N(5)) u_xdly (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .din ({rd_reg[0], wo_reg[0], e02_reg[0], e01_reg[0]}),
        .dout(xd)
    );

    assign e01x_d = xd[0 +: EW];
    assign e02x_d = xd[EW +: EW];
    assign wox_d  = xd[2*EW +: EW];
    assign rdx_d  = xd[3*EW +: EW];

    // determinant and numerators
    logic signed [EW-1:0] na [12];
    logic signed [KW-1:0] nk [12];
    logic signed [PW-1:0] np [12];

    assign na[0]  = e01x_d; assign nk[0]  = k_reg[0];
    assign na[1]  = e02x_d; assign nk[1]  = k_reg[3];
    assign na[2]  = rdx_d;  assign nk[2]  = k_reg[4];
    assign na[3]  = wox_d;  assign nk[3]  = k_reg[0];
    assign na[4]  = e02x_d; assign nk[4]  = k_reg[1];
    assign na[5]  = rdx_d;  assign nk[5]  = k_reg[2];
    assign na[6]  = e01x_d; assign nk[6]  = k_reg[1];
    assign na[7]  = wox_d;  assign nk[7]  = k_reg[3];
    assign na[8]  = rdx_d;  assign nk[8]  = k_reg[5];
    assign na[9]  = e01x_d; assign nk[9]  = k_reg[2];
    assign na[10] = e02x_d; assign nk[10] = k_reg[5];
    assign na[11] = wox_d;  assign nk[11] = k_reg[4];

    for (genvar i = 0; i < 12; i++) begin : g_mul2
        rti_mul #(.AW(EW), .BW(KW)) u_mul (
            .aclk(aclk), .en(en), .a(na[i]), .b(nk[i]), .p(np[i])
        );
    end

    logic signed [SW-1:0] det_reg, nb_reg, ng_reg, nt_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= SW'(np[0]) + SW'(np[1]) + SW'(np[2]);
            nb_reg  <= SW'(np[3]) - SW'(np[4]) - SW'(np[5]);
            ng_reg  <= SW'(np[6]) + SW'(np[7]) + SW'(np[8]);
            nt_reg  <= SW'(np[9]) - SW'(np[10]) + SW'(np[11]);
        end
    end

    // sign normalisation
    logic                 dz_reg;
    logic signed [SW-1:0] dn_reg, bn_reg, gn_reg, tn_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dz_reg <= det_reg == '0;
            if (det_reg[SW-1]) begin
                dn_reg <= -det_reg;
                bn_reg <= -nb_reg;
                gn_reg <= -ng_reg;
                tn_reg <= -nt_reg;
            end else begin
                dn_reg <= det_reg;
                bn_reg <= nb_reg;
                gn_reg <= ng_reg;
                tn_reg <= nt_reg;
            end
        end
    end

    // min distance times determinant
    logic signed [MPW-1:0] mdp;

    rti_mul #(.AW(MDW), .BW(SW)) u_mdmul (
        .aclk(aclk), .en(en),
        .a   (signed'({1'b0, md_reg})),
        .b   (dn_reg),
        .p   (mdp)
    );

    logic [4*SW:0]        nd;
    logic                 dz_d;
    logic signed [SW-1:0] dn_d, bn_d, gn_d, tn_d;

    rti_delay #(.W(4*SW+1), .N(4)) u_ndly (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .din ({dz_reg, tn_reg, gn_reg, bn_reg, dn_reg}),
        .dout(nd)
    );

    assign dn_d = nd[0 +: SW];
    assign bn_d = nd[SW +: SW];
    assign gn_d = nd[2*SW +: SW];
    assign tn_d = nd[3*SW +: SW];
    assign dz_d = nd[4*SW];

    logic [1:0] cd;

    rti_delay #(.W(2), .N(15)) u_cdly (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .din ({p2_test_reg, p2_valid_reg}),
        .dout(cd)
    );

    // hit decision
    logic signed [NUMW-1:0] num;
    logic                   ok;
    ctrl_t                  chk_reg;
    logic [NUMW-1:0]        num_reg;
    logic [SW-1:0]          den_reg;

    always_comb begin
        num = {tn_d, {FRAC_BITS{1'b0}}};
        ok  = cd[1] && !dz_d && !bn_d[SW-1] && !gn_d[SW-1]
              && ((SW+1)'(dn_d) >= (SW+1)'(bn_d) + (SW+1)'(gn_d))
              && (MPW'(num) >= mdp);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_reg <= '0;
        end else if (en) begin
            chk_reg.valid <= cd[0];
            chk_reg.hit   <= ok;
        end
        if (en) begin
            num_reg <= NUMW'(num);
            den_reg <= SW'(dn_d);
        end
    end

    ctrl_t                div_tag;
    logic [DIST_BITS-1:0] quo;

    rti_div #(.NUMW(NUMW), .DENW(SW), .QW(DIST_BITS)) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (en),
        .in_tag (chk_reg),
        .num    (num_reg),
        .den    (den_reg),
        .out_tag(div_tag),
        .quo    (quo)
    );

    // output register
    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic [DIST_BITS-1:0] m_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_tag.valid;
        end
        if (en) begin
            m_hit_reg  <= div_tag.hit;
            m_dist_reg <= div_tag.hit ? quo : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = OUT_DATA_W'(m_dist_reg);

endmodule

// File: rtl/rti_checker.sv
`timescale 1ns / 1ps

module rti_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rti_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    import rti_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero distance");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[OUT_DATA_W-1])
        else $error("distance beyond range");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
